>>> sv/wwr_pkg.sv
// Shared types and constants for the whole-word replace stream.
// No dependencies; the other design modules and the testbench import this package.
package wwr_pkg;

  localparam int unsigned WordMax    = 8;   // bytes in the pattern and replacement words
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgLenW    = 4;
  localparam int unsigned IdxW       = (WordMax > 1) ? $clog2(WordMax) : 1;
  localparam int unsigned CntW       = $clog2(WordMax + 1);
  localparam int unsigned BeatW      = $clog2(2 * WordMax);
  localparam int unsigned TotW       = $clog2(2 * WordMax + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef logic [WordMax-1:0][ByteW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatWord = 2'd0,
    CfgPatLen  = 2'd1,
    CfgRepWord = 2'd2,
    CfgRepLen  = 2'd3
  } cfg_idx_e;

  // Configuration as the matcher sees it, lengths already clamped.
  typedef struct packed {
    word_t           pat;
    logic [CntW-1:0] pat_len;
    word_t           rep;
    logic [CntW-1:0] rep_len;
  } cfg_t;

  // One queue entry: two byte segments sent back to back, then the run ends.
  typedef struct packed {
    word_t           seg_a;
    logic [CntW-1:0] len_a;
    word_t           seg_b;
    logic [CntW-1:0] len_b;
    logic            eot;
  } cmd_t;

endpackage

>>> sv/wwr_if.sv
// Valid/ready stream interfaces for the text input and the result output.
// No dependencies.
interface wwr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wwr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       end_of_output;

  modport source (output valid, output out_byte, output has_byte, output last_of_run,
                  output end_of_output, input ready);
  modport sink (input valid, input out_byte, input has_byte, input last_of_run,
                input end_of_output, output ready);
endinterface

>>> sv/wwr_config.sv
// Configuration register file with length clamping.
// Depends on wwr_pkg.
module wwr_config import wwr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [CfgDataW-1:0] pat_word_q, rep_word_q;
  logic [CfgLenW-1:0]  pat_len_q, rep_len_q;

  function automatic logic [CntW-1:0] clamp_len(input logic [CfgLenW-1:0] raw,
                                                input logic at_least_one);
    logic [CntW-1:0] res;
    if (raw > CfgLenW'(WordMax)) begin
      res = CntW'(WordMax);
    end else if (at_least_one && raw == '0) begin
      res = CntW'(1);
    end else begin
      res = CntW'(raw);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_word_q <= '0;
      pat_len_q  <= CfgLenW'(1);
      rep_word_q <= '0;
      rep_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPatWord: pat_word_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[CfgLenW-1:0];
        CfgRepWord: rep_word_q <= cfg_data_i;
        CfgRepLen:  rep_len_q  <= cfg_data_i[CfgLenW-1:0];
      endcase
    end
  end

  always_comb begin
    cfg_o.pat     = pat_word_q[WordMax*ByteW-1:0];
    cfg_o.pat_len = clamp_len(pat_len_q, 1'b1);
    cfg_o.rep     = rep_word_q[WordMax*ByteW-1:0];
    cfg_o.rep_len = clamp_len(rep_len_q, 1'b0);
  end

endmodule

>>> sv/wwr_front.sv
// Matcher front end: accepts text beats, tracks the pattern window and
// pushes one command per beat that produces output. Depends on wwr_pkg, wwr_if.
module wwr_front import wwr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  wwr_in_if.sink text_i,
  input  logic   q_full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  word_t           win_q, win_d, wp;
  logic [CntW-1:0] cnt_q, cnt_d, np, shift, last_idx, sm1;
  logic            prior_q, prior_d, pend_q, pend_d;
  logic            accept, eot, follow_letter, do_repl, found, ok;
  logic [ByteW-1:0] b;
  logic [WordMax-1:0] cand;

  function automatic logic is_letter(input logic [ByteW-1:0] c);
    // ASCII A-Z and a-z only.
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  assign text_i.ready = !q_full_i;
  assign accept       = text_i.valid && text_i.ready;

  always_comb begin
    b             = text_i.text_byte;
    eot           = text_i.end_of_text;
    follow_letter = !eot && is_letter(b);
    do_repl       = pend_q && !prior_q && !follow_letter;
    last_idx      = cnt_q - CntW'(1);

    // A pending occurrence resolves first; an end beat also flushes the window.
    cmd_o.seg_a = do_repl ? cfg_i.rep : win_q;
    cmd_o.len_a = (pend_q || eot) ? (do_repl ? cfg_i.rep_len : cnt_q) : '0;

    wp = win_q;
    if (pend_q) begin
      wp[0] = b;
      np    = CntW'(1);
    end else begin
      wp[cnt_q[IdxW-1:0]] = b;
      np                  = cnt_q + CntW'(1);
    end

    // Smallest drop count that leaves the window a prefix of the pattern.
    for (int s = 0; s < WordMax; s++) begin
      ok = 1'b1;
      for (int i = 0; i < WordMax; i++) begin
        if (s + i < WordMax) begin
          if (CntW'(s + i) < np && wp[s+i] != cfg_i.pat[i]) begin
            ok = 1'b0;
          end
        end
      end
      cand[s] = (CntW'(s) < np) && ((np - CntW'(s)) <= cfg_i.pat_len) && ok;
    end
    shift = np;
    found = 1'b0;
    for (int s = 0; s < WordMax; s++) begin
      if (!found && cand[s]) begin
        shift = CntW'(s);
        found = 1'b1;
      end
    end
    sm1 = shift - CntW'(1);

    cmd_o.seg_b = wp;
    cmd_o.len_b = eot ? '0 : shift;
    cmd_o.eot   = eot;
    push_o      = accept && (eot || cmd_o.len_a != '0 || cmd_o.len_b != '0);

    if (eot) begin
      win_d   = win_q;
      cnt_d   = '0;
      prior_d = 1'b0;
      pend_d  = 1'b0;
    end else begin
      win_d  = word_t'(wp >> (ByteW * shift));
      cnt_d  = np - shift;
      pend_d = (cnt_d != '0) && (cnt_d == cfg_i.pat_len);
      if (shift != '0) begin
        prior_d = is_letter(wp[sm1[IdxW-1:0]]);
      end else if (pend_q && cnt_q != '0) begin
        prior_d = is_letter(win_q[last_idx[IdxW-1:0]]);
      end else begin
        prior_d = prior_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prior_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (accept) begin
      cnt_q   <= cnt_d;
      prior_q <= prior_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

`ifndef SYNTHESIS
  a_pend_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cnt_q != '0))
    else $error("pending occurrence with an empty window");
  a_full_window_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(WordMax)) |-> pend_q)
    else $error("full window without a pending occurrence");
`endif

endmodule

>>> sv/wwr_queue.sv
// Short command queue between the matcher and the output sequencer.
// Depends on wwr_pkg.
module wwr_queue import wwr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] bump(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("command queue overflow");
`endif

endmodule

>>> sv/wwr_back.sv
// Output sequencer: walks the head command byte by byte into an output register.
// Depends on wwr_pkg, wwr_if.
module wwr_back import wwr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  wwr_out_if.source  result_o
);

  logic [BeatW-1:0] idx_q, idx_d, off_b;
  logic [TotW-1:0]  total;
  logic             bare, in_a, is_last, load;
  logic [ByteW-1:0] beat_byte;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             has_q, last_q, eot_q;

  always_comb begin
    total     = TotW'(head_i.len_a) + TotW'(head_i.len_b);
    bare      = total == '0;
    in_a      = TotW'(idx_q) < TotW'(head_i.len_a);
    off_b     = idx_q - BeatW'(head_i.len_a);
    beat_byte = in_a ? head_i.seg_a[idx_q[IdxW-1:0]] : head_i.seg_b[off_b[IdxW-1:0]];
    is_last   = bare || (TotW'(idx_q) + TotW'(1) == total);
    load      = q_valid_i && (!out_valid_q || result_o.ready);
    pop_o     = load && is_last;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + BeatW'(1);
      out_valid_d = 1'b1;
    end else begin
      idx_d       = idx_q;
      out_valid_d = out_valid_q && !result_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A bare end mark carries a zero byte.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= bare ? '0 : beat_byte;
      has_q  <= !bare;
      last_q <= is_last;
      eot_q  <= is_last && head_i.eot;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.out_byte      = byte_q;
  assign result_o.has_byte      = has_q;
  assign result_o.last_of_run   = last_q;
  assign result_o.end_of_output = eot_q;

`ifndef SYNTHESIS
  a_eot_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && eot_q) |-> last_q)
    else $error("end of output on a beat that does not close its run");
  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_q) |-> (eot_q && byte_q == '0))
    else $error("bare beat that is not a clean end mark");
`endif

endmodule

>>> sv/whole_word_replace_stream.sv
// Top level of the whole-word find-and-replace byte stream.
// Depends on wwr_pkg, wwr_if, wwr_config, wwr_front, wwr_queue, wwr_back.
//
//   port        dir  kind            contents
//   text_i      in   valid/ready     text_byte, end_of_text
//   result_o    out  valid/ready     out_byte, has_byte, last_of_run, end_of_output
//   cfg_*_i     in   write strobe    register index and 64-bit data
//
// The matcher takes one text beat per cycle while the two-entry command queue has room.
// The output register sends one result beat per cycle while the receiver is ready; an
// item yields 0 to 9 result beats (a bare end mark counting as one), which pass through
// a command queue entry and then the output register.
// Either side may stall; the queue absorbs replacement bursts.
// Reset clears the matcher state and the queue and loads the register defaults;
// there is no clearing pass.
module whole_word_replace_stream import wwr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wwr_in_if.sink              text_i,
  wwr_out_if.source           result_o
);

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, full, pop, head_valid;

  wwr_config u_config (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  wwr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .text_i   (text_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  wwr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_cmd)
  );

  wwr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (head_valid),
    .head_i    (head_cmd),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

>>> dv/whole_word_replace_stream_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for whole_word_replace_stream: directed table, then random text.
// Depends on wwr_pkg, the wwr_in_if/wwr_out_if interfaces and the block's RTL.
module whole_word_replace_stream_test;
  import wwr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 300;
  localparam int MaxGap      = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       eoo;
  } beat_t;

  typedef enum bit {RowCfg, RowText} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          text;
    logic                eot;
    logic                typed;
    beat_t               want;
  } row_t;

  localparam int NumRows = 31;
  localparam row_t Script [NumRows] = '{
    '{RowText, CfgPatWord, 64'h0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{RowText, CfgPatWord, 64'h0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{RowText, CfgPatWord, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'hA5, 1'b1, 1'b0, '0},
    '{RowCfg,  CfgPatWord, 64'h5A5A_5A5A_5A74_6163, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgPatLen,  64'hFFFF_FFFF_FFFF_FFF3, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgRepWord, 64'hFF80_7F01_2A47_4F44, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgRepLen,  64'h3, 8'h00, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h20, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h63, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h61, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h74, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h2E, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h63, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h61, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h74, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h73, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h5B, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h63, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h61, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h74, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h00, 1'b1, 1'b0, '0},
    '{RowCfg,  CfgPatWord, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgPatLen,  64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgRepWord, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgRepLen,  64'hF, 8'h00, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h7A, 1'b0, 1'b0, '0},
    '{RowText, CfgPatWord, 64'h0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  localparam logic [7:0] SepBytes [10] = '{8'h20, 8'h2E, 8'h2C, 8'h00, 8'h40, 8'h5B,
                                           8'h60, 8'h7B, 8'h30, 8'hE9};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  wwr_in_if  text_if();
  wwr_out_if res_if();

  whole_word_replace_stream dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .text_i     (text_if),
    .result_o   (res_if)
  );

  // Shadow registers and matcher state of the replacer.
  logic [63:0] pat_word_r;
  logic [3:0]  pat_len_r;
  logic [63:0] rep_word_r;
  logic [3:0]  rep_len_r;
  logic [7:0]  win_q [8];
  int unsigned win_cnt;
  bit          prior_alpha;
  bit          occ_pending;

  beat_t step_q[$];
  beat_t want_q[$];

  int fail_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_armed;
  logic hold_on;
  int cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic int unsigned pat_bytes();
    int unsigned n;
    n = pat_len_r;
    if (n == 0) n = 1;
    if (n > WordMax) n = WordMax;
    return n;
  endfunction

  function automatic int unsigned rep_bytes();
    int unsigned n;
    n = rep_len_r;
    if (n > WordMax) n = WordMax;
    return n;
  endfunction

  function automatic bit window_is_prefix();
    int unsigned i;
    if (win_cnt > pat_bytes()) return 1'b0;
    for (i = 0; i < win_cnt; i++)
      if (win_q[i] != pat_word_r[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_separator();
    if ($urandom_range(3) == 0) return 8'h80 | 8'($urandom_range(127));
    return SepBytes[$urandom_range(9)];
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(1) == 0) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  task automatic shift_front();
    logic [7:0] b;
    int i;
    b = win_q[0];
    step_q.push_back('{b, 1'b1, 1'b0, 1'b0});
    prior_alpha = is_alpha(b);
    for (i = 0; i < 7; i++) win_q[i] = win_q[i+1];
    win_cnt--;
  endtask

  // A held occurrence goes out whole: replaced when both neighbors are non-letters.
  task automatic settle_occurrence(input bit follower_alpha);
    int unsigned i;
    int unsigned n;
    n = (win_cnt > 8) ? 8 : win_cnt;
    if (!prior_alpha && !follower_alpha) begin
      for (i = 0; i < rep_bytes(); i++)
        step_q.push_back('{rep_word_r[8*i +: 8], 1'b1, 1'b0, 1'b0});
    end else begin
      for (i = 0; i < n; i++) step_q.push_back('{win_q[i], 1'b1, 1'b0, 1'b0});
    end
    if (n > 0) prior_alpha = is_alpha(win_q[n-1]);
    win_cnt = 0;
    occ_pending = 1'b0;
  endtask

  task automatic predict_replace(input logic [7:0] b, input bit eot);
    step_q.delete();
    if (eot) begin
      if (occ_pending) settle_occurrence(1'b0);
      while (win_cnt > 0) shift_front();
      if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      win_cnt = 0;
      prior_alpha = 1'b0;
      occ_pending = 1'b0;
    end else begin
      if (occ_pending) settle_occurrence(is_alpha(b));
      if (win_cnt > 7) begin
        while (win_cnt > 0) shift_front();
      end
      win_q[win_cnt] = b;
      win_cnt++;
      while (win_cnt > 0 && !window_is_prefix()) shift_front();
      if (win_cnt > 0 && win_cnt == pat_bytes()) occ_pending = 1'b1;
    end
  endtask

  task automatic apply_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    case (idx)
      CfgPatWord: pat_word_r = d;
      CfgPatLen:  pat_len_r  = d[3:0];
      CfgRepWord: rep_word_r = d;
      CfgRepLen:  rep_len_r  = d[3:0];
      default: ;
    endcase
  endtask

  // The caller lowers the write enable after the last write of a burst.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    apply_reg(idx, d);
  endtask

  task automatic settle_idle();
    text_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [7:0] b, input bit eot, input bit typed,
                           input beat_t typed_beat);
    int gap;
    int k;
    beat_t t;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    do @(posedge clk_i); while (!text_if.ready);
    predict_replace(b, eot);
    if (typed) begin
      want_q.push_back(typed_beat);
    end else begin
      for (k = 0; k < step_q.size(); k++) begin
        t = step_q[k];
        if (k == step_q.size() - 1) begin
          t.last = 1'b1;
          t.eoo  = eot;
        end
        want_q.push_back(t);
      end
    end
  endtask

  task automatic random_setup();
    int L;
    int i;
    int r;
    logic [63:0] pw;
    logic [63:0] rw;
    logic [3:0]  pl;
    logic [3:0]  rl;
    L = $urandom_range(1, 8);
    pw = {$urandom, $urandom};
    for (i = 0; i < L; i++) begin
      r = $urandom_range(99);
      if (r < 55)      pw[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
      else if (r < 75) pw[8*i +: 8] = 8'h41 + 8'($urandom_range(25));
      else             pw[8*i +: 8] = pick_separator();
    end
    pl = 4'(L);
    if ($urandom_range(3) == 0) begin
      if (L == 1) pl = 4'd0;
      else if (L == 8) pl = 4'($urandom_range(9, 15));
    end
    rw = {$urandom, $urandom};
    rl = 4'($urandom_range(0, 15));
    write_reg(CfgPatWord, pw);
    write_reg(CfgPatLen, {60'({$urandom, $urandom} >> 4), pl});
    write_reg(CfgRepWord, rw);
    write_reg(CfgRepLen, {60'({$urandom, $urandom} >> 4), rl});
    cfg_we <= 1'b0;
  endtask

  // Mostly pattern words and their near misses, cut apart by letters and separators.
  task automatic run_phase(input int n_items, input int idle_p, input int stall_p,
                           input bit with_hold);
    logic [7:0] tok[$];
    int sent;
    int r;
    int L;
    int i;
    int cut;
    settle_idle();
    send_idle_pct  = idle_p;
    recv_stall_pct = stall_p;
    random_setup();
    if (with_hold) hold_armed = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      tok.delete();
      L = pat_bytes();
      r = $urandom_range(99);
      if (r < 35) begin
        for (i = 0; i < L; i++) tok.push_back(pat_word_r[8*i +: 8]);
      end else if (r < 45) begin
        cut = (L > 1) ? $urandom_range(1, L - 1) : 1;
        for (i = 0; i < cut; i++) tok.push_back(pat_word_r[8*i +: 8]);
      end else if (r < 55) begin
        for (i = 0; i < L; i++) tok.push_back(pat_word_r[8*i +: 8]);
        i = $urandom_range(0, L - 1);
        tok[i] = tok[i] ^ (8'h01 << $urandom_range(7));
      end else if (r < 75) begin
        tok.push_back(pick_separator());
      end else if (r < 90) begin
        tok.push_back(pick_letter());
      end else begin
        tok.push_back(8'($urandom_range(255)));
      end
      foreach (tok[j]) begin
        send_item(tok[j], 1'b0, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(99) < 8) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_beat();
    beat_t got;
    beat_t exp_b;
    got = '{res_if.out_byte, res_if.has_byte, res_if.last_of_run, res_if.end_of_output};
    if (want_q.size() == 0) begin
      $display("%0t: result beat with nothing expected: byte %02h has %0b last %0b end %0b",
               $time, got.data, got.has, got.last, got.eoo);
      fail_cnt++;
    end else begin
      exp_b = want_q.pop_front();
      if (got.data !== exp_b.data || got.has !== exp_b.has ||
          got.last !== exp_b.last || got.eoo !== exp_b.eoo) begin
        $display("%0t: mismatch: expected byte %02h has %0b last %0b end %0b,",
                 $time, exp_b.data, exp_b.has, exp_b.last, exp_b.eoo,
                 " got byte %02h has %0b last %0b end %0b",
                 got.data, got.has, got.last, got.eoo);
        fail_cnt++;
      end
    end
  endtask

  // Sink side: check each accepted beat, then pick the next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) check_beat();
      res_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so that the queue fills and the input backs up.
  initial begin
    hold_on = 1'b0;
    wait (hold_armed);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    bit in_cfg;
    int r;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgPatWord;
    cfg_data            = '0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;
    res_if.ready        = 1'b0;
    fail_cnt            = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_armed          = 1'b0;
    in_cfg              = 1'b0;
    pat_word_r  = '0;
    pat_len_r   = 4'd1;
    rep_word_r  = '0;
    rep_len_r   = 4'd0;
    win_q       = '{default: 8'h00};
    win_cnt     = 0;
    prior_alpha = 1'b0;
    occ_pending = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      if (Script[r].kind == RowCfg) begin
        if (!in_cfg) begin
          settle_idle();
          in_cfg = 1'b1;
        end
        write_reg(Script[r].reg_idx, Script[r].data);
        if (r + 1 == NumRows || Script[r+1].kind != RowCfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
      end else begin
        send_item(Script[r].text, Script[r].eot, Script[r].typed, Script[r].want);
      end
    end

    run_phase(28, 0, 0, 1'b0);
    run_phase(28, 75, 0, 1'b0);
    run_phase(28, 0, 75, 1'b0);
    run_phase(28, 23, 23, 1'b0);
    run_phase(28, 0, 0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0, '0);

    text_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
